@@ hw/rtl/csq_pkg.sv @@
package csq_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int THREAD_ID_BITS = 8;

   localparam int TID_W     = 8;
   localparam int STATUS_W  = 3;
   localparam int REQ_W     = 2;
   localparam int CFG_W     = 10;
   localparam int COUNT_W   = 13;
   localparam int RSP_DATA_W = 24;
   localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_W   = (THREAD_ID_BITS < TID_W) ? THREAD_ID_BITS : TID_W;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 13'sd4095;

   typedef enum logic [REQ_W-1:0] {
      RQ_WAIT   = 2'd0,
      RQ_SIGNAL = 2'd1,
      RQ_CLOSE  = 2'd2,
      RQ_OPEN   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED   = 3'd0,
      ST_BLOCKED   = 3'd1,
      ST_RELEASED  = 3'd2,
      ST_QFULL     = 3'd3,
      ST_CLOSED    = 3'd4,
      ST_CLOSE_REL = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_EXEC  = 2'd1,
      S_DRAIN = 2'd2
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic drain_start;
      logic drain_pop;
   } cmd_type;

   typedef struct packed {
      logic closed;
      logic occ_zero;
      logic occ_one;
      logic out_free;
      logic req_close;
   } stat_type;

endpackage

@@ hw/rtl/csq_ram.sv @@
module csq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/csq_ctrl.sv @@
module csq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  csq_pkg::stat_type stat,
   output logic              req_tready,
   output csq_pkg::cmd_type  cmd
);
   import csq_pkg::*;

   state_type state_ff, state_in;
   logic      go_drain;

   // close of an open semaphore with waiters needs the drain loop
   assign go_drain = stat.req_close && !stat.closed && !stat.occ_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (stat.out_free) state_in = go_drain ? S_DRAIN : S_IDLE;
         end
         S_DRAIN: begin
            if (stat.out_free && stat.occ_one) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         S_EXEC: begin
            if (stat.out_free) begin
               cmd.drain_start = go_drain;
               cmd.exec        = !go_drain;
            end
         end
         S_DRAIN: begin
            cmd.drain_pop = stat.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

@@ hw/rtl/csq_dp.sv @@
module csq_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [csq_pkg::TID_W-1:0]          req_tdata,
   input  logic [csq_pkg::REQ_W-1:0]          req_tuser,
   input  logic                               csr_wr_en,
   input  logic [csq_pkg::CFG_W-1:0]          csr_wr_data,
   input  logic                               rsp_tready,
   input  csq_pkg::cmd_type                   cmd,
   output csq_pkg::stat_type                  stat,
   output logic                               rsp_tvalid,
   output logic [csq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [csq_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                               rsp_tlast
);
   import csq_pkg::*;

   req_kind_type              rtype_ff;
   logic [TID_W-1:0]          tid_ff;
   logic signed [COUNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0]          head_ff, head_in, tail_ff, tail_in;
   logic [OCC_W-1:0]          occ_ff, occ_in;
   logic                      closed_ff, closed_in;
   logic [CFG_W-1:0]          init_ff;

   logic                      vld_ff, vld_in;
   status_type                st_ff, st_in;
   logic [TID_W-1:0]          thr_ff, thr_in;
   logic                      tv_ff, tv_in;
   logic                      wbc_ff, wbc_in;
   logic signed [COUNT_W-1:0] cnt_ff;
   logic                      last_ff, last_in;
   logic                      load;

   logic                      wr_en;
   logic [STORE_W-1:0]        rd_data;
   logic signed [COUNT_W-1:0] count_up;
   logic [PTR_W-1:0]          head_inc, tail_inc;
   logic                      occ_full, out_free;

   csq_ram #(.WIDTH(STORE_W), .DEPTH(QUEUE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (STORE_W'(tid_ff)),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   assign out_free = !vld_ff || rsp_tready;
   assign occ_full = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign count_up = (count_ff < COUNT_MAX) ? count_ff + 13'sd1 : count_ff;
   assign head_inc = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_inc = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   assign stat.closed    = closed_ff;
   assign stat.occ_zero  = (occ_ff == '0);
   assign stat.occ_one   = (occ_ff == OCC_W'(1));
   assign stat.out_free  = out_free;
   assign stat.req_close = (rtype_ff == RQ_CLOSE);

   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      closed_in = closed_ff;
      wr_en     = 1'b0;
      load      = 1'b0;
      st_in     = ST_GRANTED;
      thr_in    = '0;
      tv_in     = 1'b0;
      wbc_in    = 1'b0;
      last_in   = 1'b1;
      if (cmd.exec) begin
         load = 1'b1;
         if (rtype_ff == RQ_OPEN) begin
            if (closed_ff) begin
               count_in  = signed'({{(COUNT_W - CFG_W){1'b0}}, init_ff});
               head_in   = '0;
               tail_in   = '0;
               occ_in    = '0;
               closed_in = 1'b0;
            end
         end else if (closed_ff) begin
            st_in = ST_CLOSED;
         end else begin
            case (rtype_ff)
               RQ_WAIT: begin
                  if (count_ff > 13'sd0) begin
                     count_in = count_ff - 13'sd1;
                  end else if (occ_full) begin
                     st_in = ST_QFULL;
                  end else begin
                     count_in = count_ff - 13'sd1;
                     wr_en    = 1'b1;
                     tail_in  = tail_inc;
                     occ_in   = occ_ff + 1'b1;
                     st_in    = ST_BLOCKED;
                  end
               end
               RQ_SIGNAL: begin
                  count_in = count_up;
                  if (count_up <= 13'sd0 && occ_ff != '0) begin
                     head_in = head_inc;
                     occ_in  = occ_ff - 1'b1;
                     st_in   = ST_RELEASED;
                     thr_in  = TID_W'(rd_data);
                     tv_in   = 1'b1;
                  end
               end
               RQ_CLOSE: begin
                  // no waiters here, the controller drains otherwise
                  closed_in = 1'b1;
               end
               default: st_in = ST_GRANTED;
            endcase
         end
      end else if (cmd.drain_start) begin
         closed_in = 1'b1;
      end else if (cmd.drain_pop) begin
         load     = 1'b1;
         count_in = count_up;
         occ_in   = occ_ff - 1'b1;
         st_in    = ST_CLOSE_REL;
         thr_in   = TID_W'(rd_data);
         tv_in    = 1'b1;
         wbc_in   = 1'b1;
         last_in  = (occ_ff == OCC_W'(1));
         if (occ_ff == OCC_W'(1)) begin
            head_in = '0;
            tail_in = '0;
         end else begin
            head_in = head_inc;
         end
      end
   end

   assign vld_in = load ? 1'b1 : (rsp_tready ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         occ_ff    <= '0;
         closed_ff <= 1'b1;
         init_ff   <= '0;
         vld_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         closed_ff <= closed_in;
         vld_ff    <= vld_in;
         if (csr_wr_en) init_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rtype_ff <= req_kind_type'(req_tuser);
         tid_ff   <= req_tdata;
      end
      if (load) begin
         st_ff   <= st_in;
         thr_ff  <= thr_in;
         tv_ff   <= tv_in;
         wbc_ff  <= wbc_in;
         cnt_ff  <= count_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tuser  = st_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {1'b0, cnt_ff, wbc_ff, tv_ff, thr_ff};

endmodule

@@ hw/rtl/counting_semaphore_wait_queue_core.sv @@
// Counting semaphore with a FIFO queue of blocked thread IDs. Each request
// word is accepted in IDLE and executed in EXEC against the count and the
// queue, which is bounded by the registered read of the wait-queue RAM. A
// close of an open semaphore with N waiters then enters DRAIN and releases
// one waiter per cycle while the output is free, giving N response words,
// the last flagged with rsp_tlast. A response register sits on the output,
// so a stalled rsp_tready only holds the block while the next word is due.
// The block comes out of reset closed; an open of a closed block loads the count from the csr register.
module counting_semaphore_wait_queue_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] thread_id
   input  logic [csq_pkg::TID_W-1:0]           req_tdata,
   // [1:0] req_type
   input  logic [csq_pkg::REQ_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] thread_out, [8] thread_out_valid, [9] woken_by_close,
   // [22:10] count_now, [23] zero
   output logic [csq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [2:0] status
   output logic [csq_pkg::STATUS_W-1:0]        rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [csq_pkg::CFG_W-1:0]           csr_wr_data
);
   import csq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   csq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   csq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous one still executing");

   a_thread_valid_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |->
         (rsp_tuser == ST_RELEASED) || (rsp_tuser == ST_CLOSE_REL))
      else $error("thread_out_valid on a word that releases no waiter");

   a_close_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[9] || !rsp_tlast) |->
         (rsp_tuser == ST_CLOSE_REL) && rsp_tdata[8])
      else $error("multi-word or woken_by_close response outside a close drain");

   a_count_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[22:10]) >= -$signed(COUNT_W'(QUEUE_DEPTH)))
      else $error("count went below minus the queue depth");

endmodule
